/* rtl/core/rcpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared types, constants and the built-in channel plan table.
// ----------------------------------------------------------------------------
package rcpm_pkg;

    localparam int TABLE_SIZE     = 14;
    localparam int NUM_PLANS_DEF  = 14;
    localparam int FREQ_W         = 32;
    localparam int IDX_W          = 4;
    localparam int CH_W           = 7;
    localparam int DEV_W          = 23;
    localparam int OFF_W          = 27;
    localparam int STEP_W         = 24;

    typedef struct packed {
        logic [FREQ_W-1:0] lo_hz;
        logic [FREQ_W-1:0] hi_hz;
        logic [STEP_W-1:0] step_hz;
        logic [CH_W-1:0]   count;
        logic              band;
    } plan_t;

    typedef struct packed {
        logic              ok;
        logic [CH_W-1:0]   ch;
        logic [DEV_W-1:0]  dev;
    } cand_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [CH_W-1:0]   ch;
        logic [DEV_W-1:0]  dev;
    } best_t;

    function automatic plan_t plan_at(input logic [IDX_W-1:0] i);
        plan_t p;
        p = '0;
        case (i)
            4'd0:    p = '{32'd902000000, 32'd928000000, 24'd325000, 7'd80, 1'b0};
            4'd1:    p = '{32'd860000000, 32'd886000000, 24'd520000, 7'd50, 1'b0};
            4'd2:    p = '{32'd902165000, 32'd927905000, 24'd260000, 7'd100, 1'b0};
            4'd3:    p = '{32'd860165000, 32'd885905000, 24'd260000, 7'd100, 1'b0};
            4'd4:    p = '{32'd2400000000, 32'd2480000000, 24'd1000000, 7'd80, 1'b1};
            4'd5:    p = '{32'd2400000000, 32'd2483500000, 24'd10000000, 7'd8, 1'b1};
            4'd6:    p = '{32'd2400000000, 32'd2483500000, 24'd10000000, 7'd8, 1'b1};
            4'd7:    p = '{32'd2400000000, 32'd2483500000, 24'd10000000, 7'd8, 1'b1};
            4'd8:    p = '{32'd2400000000, 32'd2480000000, 24'd1000000, 7'd80, 1'b1};
            4'd9:    p = '{32'd2400000000, 32'd2480000000, 24'd2000000, 7'd40, 1'b1};
            4'd10:   p = '{32'd2405000000, 32'd2475000000, 24'd3043000, 7'd23, 1'b1};
            4'd11:   p = '{32'd2408000000, 32'd2475000000, 24'd1000000, 7'd67, 1'b1};
            4'd12:   p = '{32'd2408000000, 32'd2475000000, 24'd4187500, 7'd16, 1'b1};
            4'd13:   p = '{32'd2400000000, 32'd2480000000, 24'd1000000, 7'd80, 1'b1};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/rf_channel_protocol_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_channel_protocol_matcher
// Matches a carrier frequency against built-in hopping channel plans.
// ----------------------------------------------------------------------------
// One request is taken every cycle unless the output is stalled; it passes through
// three lane stages (range check with reciprocal quotient, channel center
// product, rounding and deviation) and two stages of the smallest-deviation
// pick. All stages advance together and hold while the output is stalled.
module rf_channel_protocol_matcher
    import rcpm_pkg::*;
#(
    parameter int NUM_PLANS = NUM_PLANS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // freq_hz[31:0]
    input  logic        s_tuser,   // band_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // plan_index[3:0], channel_number[10:4], deviation_hz[33:11]
    output logic        m_tuser    // found
);

    localparam int DEPTH = 5;
    localparam int NP    = (NUM_PLANS < TABLE_SIZE) ? NUM_PLANS : TABLE_SIZE;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             en;
    cand_t            cands [NP];
    best_t            best;

    assign en       = m_tready || !vld_reg[DEPTH-1];
    assign s_tready = en;
    assign vld_next = {vld_reg[DEPTH-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    for (genvar g = 0; g < NP; g++)
    begin : g_lane
        rcpm_lane #(.PLAN(g)) u_lane
        (
            .clk         (clk),
            .en          (en),
            .freq_hz     (s_tdata),
            .band_select (s_tuser),
            .cand        (cands[g])
        );
    end

    rcpm_select #(.NUM_PLANS(NP)) u_select
    (
        .clk   (clk),
        .en    (en),
        .cands (cands),
        .best  (best)
    );

    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tuser  = best.found;
    assign m_tdata  = {(40 - IDX_W - CH_W - DEV_W)'(0), best.dev, best.ch, best.idx};

endmodule

/* rtl/core/rcpm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_lane
// One plan lane: range check, nearest channel by reciprocal, deviation check.
// ----------------------------------------------------------------------------
module rcpm_lane
    import rcpm_pkg::*;
#(
    parameter int PLAN = 0
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [FREQ_W-1:0] freq_hz,
    input  logic              band_select,
    output cand_t             cand
);

    localparam plan_t P       = plan_at(IDX_W'(PLAN));
    localparam int    RSH     = 40;
    localparam longint RECIP  = ((64'd1 << RSH) + longint'(P.step_hz) - 1)
                                / longint'(P.step_hz);

    logic              in_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [OFF_W-1:0]  q_next;
    logic [CH_W+1:0]   q_reg;
    logic [OFF_W+STEP_W-1:0] prod;
    logic [OFF_W:0]    rem;
    logic [CH_W+1:0]   ch;
    logic [OFF_W:0]    dev;
    logic              ok;
    logic [CH_W-1:0]   ch_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic              ok_reg;
    logic [OFF_W+STEP_W-1:0] cen;
    logic [OFF_W+STEP_W-1:0] cen_reg;
    logic [OFF_W-1:0]  off3_reg;
    logic              in3_reg;
    logic [CH_W+1:0]   q3_reg;

    logic [FREQ_W:0]   diff;
    logic [OFF_W+RSH+2:0] qm;

    assign diff = {1'b0, freq_hz} - {1'b0, P.lo_hz};
    assign qm   = (OFF_W+RSH+3)'(diff[OFF_W-1:0]) * (OFF_W+RSH+3)'(RECIP);
    assign q_next = OFF_W'(qm >> RSH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg  <= (band_select == P.band) && (freq_hz >= P.lo_hz)
                       && (freq_hz <= P.hi_hz);
            off_reg <= diff[OFF_W-1:0];
            q_reg   <= (CH_W+2)'(q_next);
        end
    end

    assign prod = (OFF_W+STEP_W)'(q_reg) * (OFF_W+STEP_W)'(P.step_hz);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cen_reg  <= prod;
            off3_reg <= off_reg;
            in3_reg  <= in_reg;
            q3_reg   <= q_reg;
        end
    end

    always_comb
    begin
        cen = cen_reg;
        ch  = q3_reg;
        rem = (OFF_W+1)'(off3_reg) - (OFF_W+1)'(cen[OFF_W-1:0]);
        if (cen > (OFF_W+STEP_W)'(off3_reg))
        begin
            ch  = q3_reg - 1'b1;
            rem = (OFF_W+1)'(off3_reg) + (OFF_W+1)'(P.step_hz)
                  - (OFF_W+1)'(cen[OFF_W-1:0]);
        end
        if ((rem << 1) >= (OFF_W+1)'(P.step_hz))
        begin
            ch  = ch + 1'b1;
            dev = (OFF_W+1)'(P.step_hz) - rem;
        end
        else
        begin
            dev = rem;
        end
        ok = in3_reg && (ch < (CH_W+2)'(P.count)) && ((dev << 1) < (OFF_W+1)'(P.step_hz));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg  <= ok;
            ch_reg  <= ch[CH_W-1:0];
            dev_reg <= dev[DEV_W-1:0];
        end
    end

    assign cand = '{ok_reg, ch_reg, dev_reg};

endmodule

/* rtl/core/rcpm_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_select
// Registered pick of the accepted lane with the smallest deviation.
// ----------------------------------------------------------------------------
module rcpm_select
    import rcpm_pkg::*;
#(
    parameter int NUM_PLANS = NUM_PLANS_DEF
)
(
    input  logic  clk,
    input  logic  en,
    input  cand_t cands [NUM_PLANS],
    output best_t best
);

    localparam int HALF = (NUM_PLANS + 1) / 2;

    best_t half_next [2];
    best_t half_reg  [2];
    best_t best_next;

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            half_next[h] = '0;
            for (int p = h * HALF; p < NUM_PLANS && p < (h + 1) * HALF; p++)
            begin
                if (cands[p].ok && (!half_next[h].found || cands[p].dev < half_next[h].dev))
                begin
                    half_next[h] = '{1'b1, IDX_W'(p), cands[p].ch, cands[p].dev};
                end
            end
        end
        best_next = half_reg[0];
        if (half_reg[1].found && (!half_reg[0].found || half_reg[1].dev < half_reg[0].dev))
        begin
            best_next = half_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            half_reg <= half_next;
            best     <= best_next;
        end
    end

endmodule

/* rtl/core/rcpm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
module rcpm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready) else $error("ready low with empty output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 40'd0) else $error("no-match fields nonzero");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= 4'd13) else $error("plan index out of range");

endmodule

bind rf_channel_protocol_matcher rcpm_checker u_rcpm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
